@@ hw/rtl/sspr_pkg.sv @@
// Shared types, codes and the CRC update function for the status packet receiver.
package sspr_pkg;

    localparam int QueueDepth = 4;
    localparam int QueueAw = $clog2(QueueDepth);

    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_BYTE    = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    localparam logic [1:0] CFG_EXPECTED_ID     = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_LENGTH = 2'd1;
    localparam logic [1:0] CFG_DATA_COUNT      = 2'd2;
    localparam logic [1:0] CFG_FAST_MODE       = 2'd3;

    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_HDR_TIMEOUT  = 4'd1;
    localparam logic [3:0] ST_PREAMBLE     = 4'd2;
    localparam logic [3:0] ST_ID           = 4'd3;
    localparam logic [3:0] ST_LENGTH       = 4'd4;
    localparam logic [3:0] ST_INSTR        = 4'd5;
    localparam logic [3:0] ST_ERR_TIMEOUT  = 4'd6;
    localparam logic [3:0] ST_DATA_TIMEOUT = 4'd7;
    localparam logic [3:0] ST_CRC_TIMEOUT  = 4'd8;
    localparam logic [3:0] ST_CRC_BAD      = 4'd9;

    localparam logic [2:0] HDR_LAST_INDEX = 3'd7;
    localparam logic [7:0] INSTR_STATUS   = 8'h55;
    localparam logic [15:0] CRC_POLY      = 16'h8005;

    localparam logic [7:0] CFG_ID_RESET     = 8'd1;
    localparam logic [15:0] CFG_LEN_RESET   = 16'd3;

    typedef enum logic [1:0] {
        ITEM_START,
        ITEM_BYTE,
        ITEM_TIMEOUT
    } item_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_ERROR,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    typedef struct packed {
        item_kind_t kind;
        logic [7:0] rx_byte;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic [7:0]  expected_id;
        logic [15:0] expected_length;
        logic [7:0]  data_count;
        logic        fast_mode;
    } cfg_t;

    function automatic logic [7:0] preamble_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0: val = 8'hFF;
            2'd1: val = 8'hFF;
            2'd2: val = 8'hFD;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/sspr_front.sv @@
// Input side: takes transactions and classifies them into queue entries.
module sspr_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    input  logic [1:0]          s_tuser,   // [1:0] req_type
    input  logic                q_full,
    output sspr_pkg::q_push_t   q_push
);

    sspr_pkg::item_kind_t kind;
    logic                 known;

    always_comb begin
        kind  = sspr_pkg::ITEM_START;
        known = 1'b1;
        case (s_tuser)
            sspr_pkg::REQ_START:   kind = sspr_pkg::ITEM_START;
            sspr_pkg::REQ_BYTE:    kind = sspr_pkg::ITEM_BYTE;
            sspr_pkg::REQ_TIMEOUT: kind = sspr_pkg::ITEM_TIMEOUT;
            default:               known = 1'b0;
        endcase
    end

    assign s_tready = !q_full;

    // Unknown request types are accepted and dropped here.
    assign q_push.valid         = s_tvalid && s_tready && known;
    assign q_push.entry.kind    = kind;
    assign q_push.entry.rx_byte = s_tdata;

endmodule

@@ hw/rtl/sspr_queue.sv @@
// Short queue of classified items between the input side and the packet engine.
module sspr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  sspr_pkg::q_push_t   q_push,
    output logic                q_full,
    output logic                q_valid,
    output sspr_pkg::q_entry_t  q_head,
    input  logic                q_pop
);

    sspr_pkg::q_entry_t            slots_reg [sspr_pkg::QueueDepth];
    logic [sspr_pkg::QueueAw-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [sspr_pkg::QueueAw-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [sspr_pkg::QueueAw:0]    count_reg, count_next;
    logic                          do_pop;

    assign q_full  = count_reg == (sspr_pkg::QueueAw+1)'(sspr_pkg::QueueDepth);
    assign q_valid = count_reg != '0;
    assign q_head  = slots_reg[rd_ptr_reg];
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.valid) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (q_push.valid && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!q_push.valid && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.valid) begin
            slots_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

@@ hw/rtl/sspr_back.sv @@
// Packet engine: header checks, CRC, data pass-through and the output register.
module sspr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  sspr_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  sspr_pkg::q_entry_t  q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // [7:0] data_byte, [11:8] status_code,
                                           // [19:12] device_error, [23:20] zero
    output logic                m_tuser,   // [0] out_kind
    output logic                m_tlast    // last
);

    sspr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic [2:0]  header_fault_reg, header_fault_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  crc_low_byte_reg, crc_low_byte_next;
    logic [7:0]  error_byte_reg, error_byte_next;
    logic [7:0]  length_low_byte_reg, length_low_byte_next;
    logic        have_error_byte_reg, have_error_byte_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic [3:0]  out_status_reg, out_status_next;
    logic [7:0]  out_dev_err_reg, out_dev_err_next;
    logic        out_last_reg, out_last_next;

    logic [7:0]  b;
    logic [15:0] crc_upd;
    logic [2:0]  fault_cur;
    logic [2:0]  fault_eff;
    logic        emit;
    logic [3:0]  emit_code;

    assign b       = q_head.rx_byte;
    assign crc_upd = sspr_pkg::crc_feed(running_crc_reg, b);
    assign q_pop   = q_valid && (!out_valid_reg || m_tready);

    always_comb begin
        fault_cur = '0;
        case (byte_index_reg[2:0])
            3'd0, 3'd1, 3'd2, 3'd3: begin
                if (b != sspr_pkg::preamble_byte(byte_index_reg[1:0])) begin
                    fault_cur = sspr_pkg::ST_PREAMBLE[2:0];
                end
            end
            3'd4: begin
                if (b != cfg.expected_id) begin
                    fault_cur = sspr_pkg::ST_ID[2:0];
                end
            end
            3'd5: fault_cur = '0;
            3'd6: begin
                if ({b, length_low_byte_reg} != cfg.expected_length) begin
                    fault_cur = sspr_pkg::ST_LENGTH[2:0];
                end
            end
            default: begin
                if (b != sspr_pkg::INSTR_STATUS) begin
                    fault_cur = sspr_pkg::ST_INSTR[2:0];
                end
            end
        endcase
        fault_eff = (header_fault_reg != '0) ? header_fault_reg : fault_cur;
    end

    always_comb begin
        phase_next           = phase_reg;
        byte_index_next      = byte_index_reg;
        header_fault_next    = header_fault_reg;
        running_crc_next     = running_crc_reg;
        crc_low_byte_next    = crc_low_byte_reg;
        error_byte_next      = error_byte_reg;
        length_low_byte_next = length_low_byte_reg;
        have_error_byte_next = have_error_byte_reg;
        out_valid_next       = out_valid_reg && !m_tready;
        out_kind_next        = out_kind_reg;
        out_data_next        = out_data_reg;
        out_status_next      = out_status_reg;
        out_dev_err_next     = out_dev_err_reg;
        out_last_next        = out_last_reg;
        emit                 = 1'b0;
        emit_code            = sspr_pkg::ST_OK;

        if (q_pop) begin
            case (q_head.kind)
                sspr_pkg::ITEM_START: begin
                    byte_index_next      = '0;
                    header_fault_next    = '0;
                    running_crc_next     = '0;
                    crc_low_byte_next    = '0;
                    error_byte_next      = '0;
                    length_low_byte_next = '0;
                    have_error_byte_next = 1'b0;
                    phase_next = cfg.fast_mode ? sspr_pkg::PH_ERROR : sspr_pkg::PH_HEADER;
                end
                sspr_pkg::ITEM_TIMEOUT: begin
                    case (phase_reg)
                        sspr_pkg::PH_HEADER: begin
                            emit      = 1'b1;
                            emit_code = sspr_pkg::ST_HDR_TIMEOUT;
                        end
                        sspr_pkg::PH_ERROR: begin
                            emit      = 1'b1;
                            emit_code = sspr_pkg::ST_ERR_TIMEOUT;
                        end
                        sspr_pkg::PH_DATA: begin
                            emit      = 1'b1;
                            emit_code = sspr_pkg::ST_DATA_TIMEOUT;
                        end
                        sspr_pkg::PH_CRC_LO, sspr_pkg::PH_CRC_HI: begin
                            emit      = 1'b1;
                            emit_code = sspr_pkg::ST_CRC_TIMEOUT;
                        end
                        default: emit = 1'b0;
                    endcase
                end
                sspr_pkg::ITEM_BYTE: begin
                    case (phase_reg)
                        sspr_pkg::PH_HEADER: begin
                            running_crc_next  = crc_upd;
                            header_fault_next = fault_eff;
                            if (byte_index_reg[2:0] == 3'd5) begin
                                length_low_byte_next = b;
                            end
                            if (byte_index_reg[2:0] == sspr_pkg::HDR_LAST_INDEX) begin
                                if (fault_eff != '0) begin
                                    emit      = 1'b1;
                                    emit_code = {1'b0, fault_eff};
                                end else begin
                                    phase_next      = sspr_pkg::PH_ERROR;
                                    byte_index_next = '0;
                                end
                            end else begin
                                byte_index_next = byte_index_reg + 8'd1;
                            end
                        end
                        sspr_pkg::PH_ERROR: begin
                            running_crc_next     = crc_upd;
                            error_byte_next      = b;
                            have_error_byte_next = 1'b1;
                            byte_index_next      = '0;
                            phase_next = (cfg.data_count == '0) ? sspr_pkg::PH_CRC_LO
                                                                : sspr_pkg::PH_DATA;
                        end
                        sspr_pkg::PH_DATA: begin
                            running_crc_next = crc_upd;
                            out_valid_next   = 1'b1;
                            out_kind_next    = 1'b0;
                            out_data_next    = b;
                            out_status_next  = sspr_pkg::ST_OK;
                            out_dev_err_next = error_byte_reg;
                            out_last_next    = 1'b0;
                            if ({1'b0, byte_index_reg} + 9'd1 >= {1'b0, cfg.data_count}) begin
                                phase_next      = sspr_pkg::PH_CRC_LO;
                                byte_index_next = '0;
                            end else begin
                                byte_index_next = byte_index_reg + 8'd1;
                            end
                        end
                        sspr_pkg::PH_CRC_LO: begin
                            crc_low_byte_next = b;
                            phase_next        = sspr_pkg::PH_CRC_HI;
                        end
                        sspr_pkg::PH_CRC_HI: begin
                            emit      = 1'b1;
                            emit_code = ({b, crc_low_byte_reg} == running_crc_reg)
                                        ? sspr_pkg::ST_OK : sspr_pkg::ST_CRC_BAD;
                        end
                        default: emit = 1'b0;
                    endcase
                end
                default: emit = 1'b0;
            endcase
        end

        if (emit) begin
            out_valid_next   = 1'b1;
            out_kind_next    = 1'b1;
            out_data_next    = '0;
            out_status_next  = emit_code;
            out_dev_err_next = have_error_byte_reg ? error_byte_reg : 8'd0;
            out_last_next    = 1'b1;
            phase_next       = sspr_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= sspr_pkg::PH_IDLE;
            byte_index_reg      <= '0;
            header_fault_reg    <= '0;
            running_crc_reg     <= '0;
            crc_low_byte_reg    <= '0;
            error_byte_reg      <= '0;
            length_low_byte_reg <= '0;
            have_error_byte_reg <= 1'b0;
            out_valid_reg       <= 1'b0;
        end else begin
            phase_reg           <= phase_next;
            byte_index_reg      <= byte_index_next;
            header_fault_reg    <= header_fault_next;
            running_crc_reg     <= running_crc_next;
            crc_low_byte_reg    <= crc_low_byte_next;
            error_byte_reg      <= error_byte_next;
            length_low_byte_reg <= length_low_byte_next;
            have_error_byte_reg <= have_error_byte_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg    <= out_kind_next;
        out_data_reg    <= out_data_next;
        out_status_reg  <= out_status_next;
        out_dev_err_reg <= out_dev_err_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_dev_err_reg, out_status_reg, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ hw/rtl/servo_status_packet_v2_receiver.sv @@
// Top level of the servo bus status packet receiver.
//
// The input stream carries one request per transaction: s_tuser holds the
// request type (start, received byte or read timeout) and s_tdata the byte.
// The output stream gives data bytes as they pass (m_tuser low) and one final
// status per packet (m_tuser high, m_tlast high) with the device error byte.
// Registers are written through the cfg channel, which is always ready, and
// should only be written while no packet is in flight.
// A request accepted into the queue is handled by the packet engine, whose
// result is registered before it appears on m_tdata. While the output is
// not stalled by m_tready the block sustains one request per cycle: the
// classifier, the four-entry queue and the packet engine each pass one item
// a cycle, and the CRC update of one byte is done within the engine's cycle.
// Reset returns the registers to their defaults, empties the queue and leaves
// the engine idle with no result pending.
// When the receiver stalls the output holds its transaction, the engine stops
// and the queue fills; s_tready falls once the queue holds four items.
module servo_status_packet_v2_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [1:0]  s_tuser,    // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] data_byte, [11:8] status_code,
                                    // [19:12] device_error, [23:20] zero
    output logic        m_tuser,    // [0] out_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    sspr_pkg::cfg_t     cfg_reg;
    sspr_pkg::q_push_t  q_push;
    sspr_pkg::q_entry_t q_head;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_id     <= sspr_pkg::CFG_ID_RESET;
            cfg_reg.expected_length <= sspr_pkg::CFG_LEN_RESET;
            cfg_reg.data_count      <= '0;
            cfg_reg.fast_mode       <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sspr_pkg::CFG_EXPECTED_ID:     cfg_reg.expected_id     <= cfg_data[7:0];
                sspr_pkg::CFG_EXPECTED_LENGTH: cfg_reg.expected_length <= cfg_data;
                sspr_pkg::CFG_DATA_COUNT:      cfg_reg.data_count      <= cfg_data[7:0];
                sspr_pkg::CFG_FAST_MODE:       cfg_reg.fast_mode       <= cfg_data[0];
                default:                       cfg_reg.fast_mode       <= cfg_reg.fast_mode;
            endcase
        end
    end

    sspr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push)
    );

    sspr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    sspr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/sspr_checker.sv @@
// Port-level checks on the receiver's output stream, bound to the top level.
module sspr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output transaction present straight after reset");

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[7:0] == 8'd0))
        else $error("status transaction without last or with a data byte");

    a_data_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (!m_tlast && m_tdata[11:8] == 4'd0))
        else $error("data transaction with last or a status code");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output transaction changed");

endmodule

bind servo_status_packet_v2_receiver sspr_checker u_sspr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
